// File: hdl/stct_pkg.sv
// shared types and constants for the sample trace count table
package stct_pkg;

    // default sizes
    localparam int ENTRIES_DEF   = 64;
    localparam int MAX_DEPTH_DEF = 16;

    // counts and totals
    localparam int CNT_W = 61;
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    // trace depth register
    localparam int TD_W = 5;
    localparam logic [TD_W-1:0] TD_RESET = 5'd16;

    // opcodes
    localparam logic [1:0] OP_FRAME = 2'd0;
    localparam logic [1:0] OP_GC    = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;
    localparam logic [1:0] OP_CLEAR = 2'd3;

    // result status codes
    localparam logic [2:0] ST_HIT       = 3'd0;
    localparam logic [2:0] ST_NEW       = 3'd1;
    localparam logic [2:0] ST_NEW_EVICT = 3'd2;
    localparam logic [2:0] ST_READOUT   = 3'd3;
    localparam logic [2:0] ST_DONE      = 3'd4;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [63:0] frame_address;
        logic        last_frame;
        logic [31:0] weight;
        logic [5:0]  read_slot;
        logic [3:0]  read_word;
    } sample_t;

    typedef struct packed {
        logic [2:0]       status;
        logic [5:0]       entry_slot;
        logic [CNT_W-1:0] entry_count;
        logic [63:0]      key_word;
        logic [6:0]       evicted_entries;
        logic [CNT_W-1:0] gc_total;
        logic [CNT_W-1:0] discarded_total;
    } result_t;

    // median unit to sequencer
    typedef struct packed {
        logic             done;
        logic [CNT_W-1:0] median;
    } med_status_t;

endpackage

// File: hdl/stct_ram.sv
// simple dual port ram with registered read data
module stct_ram #(
    parameter int WIDTH = stct_pkg::CNT_W,
    parameter int DEPTH = stct_pkg::ENTRIES_DEF,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: hdl/stct_median.sv
// approximate median of the slot counts, median-of-three tree walked with a stack
module stct_median #(
    parameter int ENTRIES = stct_pkg::ENTRIES_DEF,
    localparam int SW = $clog2(ENTRIES)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [stct_pkg::CNT_W-1:0]    count,
    output logic [SW-1:0]                 raddr,
    output stct_pkg::med_status_t         outcome
);

    localparam int ZW   = SW + 1;
    localparam int STK  = SW + 1;
    localparam int IW   = $clog2(STK);
    localparam int PTRW = $clog2(STK + 1);
    localparam int CW   = stct_pkg::CNT_W;
    localparam logic [15:0] DIV3_MUL = 16'd43691;
    localparam int DIV3_SHIFT = 17;

    localparam logic [2:0] M_IDLE   = 3'd0;
    localparam logic [2:0] M_CALL   = 3'd1;
    localparam logic [2:0] M_LEAF_A = 3'd2;
    localparam logic [2:0] M_LEAF_B = 3'd3;
    localparam logic [2:0] M_RET    = 3'd4;

    typedef struct packed {
        logic [SW-1:0] start;
        logic [ZW-1:0] size;
        logic [ZW-1:0] third;
        logic [1:0]    phase;
        logic [CW-1:0] a;
        logic [CW-1:0] b;
    } frame_t;

    // floor(v / 3) through a reciprocal, exact below 2^16
    function automatic logic [ZW-1:0] div3(input logic [ZW-1:0] v);
        logic [ZW+15:0] p;
        p = (ZW+16)'(v) * (ZW+16)'(DIV3_MUL);
        return ZW'(p >> DIV3_SHIFT);
    endfunction

    function automatic logic [CW-1:0] med3(input logic [CW-1:0] a,
                                           input logic [CW-1:0] b,
                                           input logic [CW-1:0] c);
        if (a < b)
            return (b < c) ? b : ((a > c) ? a : c);
        return (a < c) ? a : ((b > c) ? b : c);
    endfunction

    frame_t          stack_reg [STK];
    logic [PTRW-1:0] sp_reg;
    logic [2:0]      mstate_reg;
    logic [CW-1:0]   ret_reg;
    logic [CW-1:0]   x_reg;

    frame_t        top_f;
    frame_t        child_call;
    frame_t        child_mid;
    frame_t        child_hi;
    frame_t        root_f;
    logic [ZW-1:0] two_third;
    logic [ZW-1:0] hi_size;
    logic [CW:0]   pair_sum;

    always_comb
    begin
        top_f     = stack_reg[IW'(sp_reg - PTRW'(1))];
        two_third = top_f.third << 1;
        hi_size   = top_f.size - two_third;

        child_call       = '0;
        child_call.start = top_f.start;
        child_call.size  = top_f.third;
        child_call.third = div3(top_f.third);

        child_mid       = '0;
        child_mid.start = top_f.start + SW'(top_f.third);
        child_mid.size  = top_f.third;
        child_mid.third = div3(top_f.third);

        child_hi       = '0;
        child_hi.start = top_f.start + SW'(two_third);
        child_hi.size  = hi_size;
        child_hi.third = div3(hi_size);

        root_f       = '0;
        root_f.size  = ZW'(ENTRIES);
        root_f.third = ZW'(ENTRIES / 3);

        pair_sum = {1'b0, x_reg} + {1'b0, count};

        raddr = (mstate_reg == M_LEAF_A) ? top_f.start + SW'(1) : top_f.start;
    end

    assign outcome.done   = (mstate_reg == M_RET) && (sp_reg == '0);
    assign outcome.median = ret_reg;

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mstate_reg <= M_IDLE;
            sp_reg     <= '0;
        end
        else
        begin
            case (mstate_reg)
                M_IDLE:
                begin
                    if (start)
                    begin
                        sp_reg     <= PTRW'(1);
                        mstate_reg <= M_CALL;
                    end
                end
                M_CALL:
                begin
                    if (top_f.size < ZW'(3))
                    begin
                        mstate_reg <= M_LEAF_A;
                    end
                    else
                    begin
                        sp_reg <= sp_reg + PTRW'(1);
                    end
                end
                M_LEAF_A:
                begin
                    if (top_f.size < ZW'(2))
                    begin
                        sp_reg     <= sp_reg - PTRW'(1);
                        mstate_reg <= M_RET;
                    end
                    else
                    begin
                        mstate_reg <= M_LEAF_B;
                    end
                end
                M_LEAF_B:
                begin
                    sp_reg     <= sp_reg - PTRW'(1);
                    mstate_reg <= M_RET;
                end
                M_RET:
                begin
                    if (sp_reg == '0)
                    begin
                        mstate_reg <= M_IDLE;
                    end
                    else if (top_f.phase == 2'd2)
                    begin
                        sp_reg <= sp_reg - PTRW'(1);
                    end
                    else
                    begin
                        sp_reg     <= sp_reg + PTRW'(1);
                        mstate_reg <= M_CALL;
                    end
                end
                default:
                begin
                    mstate_reg <= M_IDLE;
                end
            endcase
        end
    end

    // stack frames and partial results
    always_ff @(posedge clk)
    begin
        case (mstate_reg)
            M_IDLE:
            begin
                if (start)
                begin
                    stack_reg[0] <= root_f;
                end
            end
            M_CALL:
            begin
                if (top_f.size >= ZW'(3))
                begin
                    stack_reg[IW'(sp_reg)] <= child_call;
                end
            end
            M_LEAF_A:
            begin
                ret_reg <= count;
                x_reg   <= count;
            end
            M_LEAF_B:
            begin
                ret_reg <= pair_sum[CW:1];
            end
            M_RET:
            begin
                if (sp_reg != '0)
                begin
                    case (top_f.phase)
                        2'd0:
                        begin
                            stack_reg[IW'(sp_reg - PTRW'(1))].a     <= ret_reg;
                            stack_reg[IW'(sp_reg - PTRW'(1))].phase <= 2'd1;
                            stack_reg[IW'(sp_reg)]                  <= child_mid;
                        end
                        2'd1:
                        begin
                            stack_reg[IW'(sp_reg - PTRW'(1))].b     <= ret_reg;
                            stack_reg[IW'(sp_reg - PTRW'(1))].phase <= 2'd2;
                            stack_reg[IW'(sp_reg)]                  <= child_hi;
                        end
                        default:
                        begin
                            ret_reg <= med3(top_f.a, top_f.b, ret_reg);
                        end
                    endcase
                end
            end
            default:
            begin
                x_reg <= x_reg;
            end
        endcase
    end

endmodule

// File: hdl/sample_trace_count_table.sv
// top level of the sample trace count table: sequencer, slot and key memories
// last frame: match walks slots, skipping empty slots and comparing each stored key
//   word by word, then allocates; a full table adds the median walk and an eviction
//   sweep over every slot, all paced by the single slot memory port
// throughput: one item at a time; a finished word waits in the output register
// reset: a sweep over all ENTRIES slots clears counts and relinks the free list, no
//   item taken meanwhile (config writes are); key words stay undefined until written
module sample_trace_count_table #(
    parameter int ENTRIES   = stct_pkg::ENTRIES_DEF,
    parameter int MAX_DEPTH = stct_pkg::MAX_DEPTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        sample_valid,
    output logic                        sample_ready,
    input  stct_pkg::sample_t           sample,
    output logic                        result_valid,
    input  logic                        result_ready,
    output stct_pkg::result_t           result,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [stct_pkg::TD_W-1:0]   cfg_data
);

    localparam int CW  = stct_pkg::CNT_W;
    localparam int SW  = $clog2(ENTRIES);
    localparam int LKW = SW + 1;                     // link, holds the none mark
    localparam int DW  = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int PW  = $clog2(MAX_DEPTH + 1);
    localparam int SMW = LKW + CW;                   // slot word: {link, count}
    localparam int KAW = SW + DW;
    localparam logic [LKW-1:0] LINK_NONE = LKW'(ENTRIES);

    // sequencer states
    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_READ   = 4'd2;
    localparam logic [3:0] S_MCNT   = 4'd3;
    localparam logic [3:0] S_MCHK   = 4'd4;
    localparam logic [3:0] S_MKEY   = 4'd5;
    localparam logic [3:0] S_MED    = 4'd6;
    localparam logic [3:0] S_EVRD   = 4'd7;
    localparam logic [3:0] S_EVCHK  = 4'd8;
    localparam logic [3:0] S_ALLOC  = 4'd9;
    localparam logic [3:0] S_ALLOCW = 4'd10;
    localparam logic [3:0] S_KWR    = 4'd11;
    localparam logic [3:0] S_DONE   = 4'd12;

    function automatic logic [CW-1:0] sat_add(input logic [CW-1:0] a,
                                              input logic [CW-1:0] b);
        logic [CW:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CW] ? stct_pkg::CNT_MAX : s[CW-1:0];
    endfunction

    // control state
    logic [3:0]                state_reg;
    logic [SW-1:0]             idx_reg;      // slot walk
    logic [DW-1:0]             j_reg;        // key word walk
    logic [PW-1:0]             pos_reg;      // frames seen in the current trace
    logic [MAX_DEPTH-1:0]      kept_reg;     // frames stored in the current trace
    logic [stct_pkg::TD_W-1:0] depth_reg;
    logic [CW-1:0]             gc_reg;
    logic [CW-1:0]             disc_reg;
    logic [LKW-1:0]            head_reg;     // free list head
    logic                      clr_pend_reg; // clear op waiting on the sweep
    logic                      res_valid_reg;

    // payload
    logic [63:0]         buf_reg [MAX_DEPTH];
    logic [31:0]         w_reg;
    logic [CW-1:0]       cnt_reg;
    logic [LKW-1:0]      link_reg;
    logic [SW-1:0]       slot_reg;
    logic [CW-1:0]       med_reg;
    logic [LKW-1:0]      nev_reg;
    logic [2:0]          status_reg;
    logic [5:0]          oslot_reg;
    logic [CW-1:0]       ocnt_reg;
    logic [63:0]         oword_reg;
    logic                rd_ok_reg;
    logic                wd_ok_reg;
    stct_pkg::result_t   res_reg;

    // memory ports
    logic                slot_we;
    logic [SW-1:0]       slot_waddr;
    logic [SMW-1:0]      slot_wdata;
    logic [SW-1:0]       slot_raddr;
    logic [SMW-1:0]      slot_rdata;
    logic                key_we;
    logic [KAW-1:0]      key_waddr;
    logic [KAW-1:0]      key_raddr;
    logic [63:0]         key_rdata;

    // median unit
    logic                  med_start;
    logic [SW-1:0]         med_raddr;
    stct_pkg::med_status_t med_st;

    // decode
    logic                acc;
    logic                res_load;
    logic [PW-1:0]       depth_use;
    logic                frame_keep;
    logic [63:0]         expect_word;
    logic [CW-1:0]       slot_cnt;
    logic [LKW-1:0]      slot_link;
    logic                last_slot;
    logic                j_end;
    logic                key_mismatch;
    logic                cnt_zero;
    logic                match_hit;
    logic                match_miss;
    logic                match_next;
    logic                head_empty;
    logic [SW-1:0]       alloc_slot;
    logic [CW-1:0]       hit_sum;
    logic                evict_now;
    logic [31:0]         weight_nz;

    assign acc          = sample_valid && sample_ready;
    assign sample_ready = (state_reg == S_IDLE);
    assign cfg_ready    = 1'b1;
    assign result_valid = res_valid_reg;
    assign result       = res_reg;
    assign res_load     = (state_reg == S_DONE) && (!res_valid_reg || result_ready);

    // depth out of range clamps to 1 .. MAX_DEPTH
    always_comb
    begin
        if (depth_reg == '0)
            depth_use = PW'(1);
        else if (int'(depth_reg) > MAX_DEPTH)
            depth_use = PW'(MAX_DEPTH);
        else
            depth_use = PW'(depth_reg);
    end

    assign frame_keep = int'(pos_reg) < int'(depth_use);

    // frames not stored in this trace read as zero
    assign expect_word = kept_reg[j_reg] ? buf_reg[j_reg] : 64'd0;

    assign slot_cnt     = slot_rdata[CW-1:0];
    assign slot_link    = slot_rdata[SMW-1:CW];
    assign last_slot    = (idx_reg == SW'(ENTRIES - 1));
    assign j_end        = (j_reg == DW'(MAX_DEPTH - 1));
    assign key_mismatch = (key_rdata != expect_word);
    assign cnt_zero     = (slot_cnt == '0);

    assign match_hit  = (state_reg == S_MKEY) && !key_mismatch && j_end;
    assign match_miss = ((state_reg == S_MCHK) && cnt_zero && last_slot)
                     || ((state_reg == S_MKEY) && key_mismatch && last_slot);
    assign match_next = ((state_reg == S_MCHK) && cnt_zero && !last_slot)
                     || ((state_reg == S_MKEY) && key_mismatch && !last_slot);

    assign head_empty = (head_reg >= LINK_NONE);
    assign alloc_slot = head_empty ? '0 : head_reg[SW-1:0];
    assign hit_sum    = sat_add(cnt_reg, CW'(w_reg));
    assign evict_now  = (state_reg == S_EVCHK) && (slot_cnt <= med_reg);
    // a zero weight on a last frame counts as one
    assign weight_nz  = (sample.weight == '0) ? 32'd1 : sample.weight;
    assign med_start  = match_miss && head_empty;

    // slot memory port steering
    always_comb
    begin
        case (state_reg)
            S_IDLE:  slot_raddr = SW'(sample.read_slot);
            S_MED:   slot_raddr = med_raddr;
            S_ALLOC: slot_raddr = alloc_slot;
            default: slot_raddr = idx_reg;
        endcase

        slot_we    = 1'b0;
        slot_waddr = idx_reg;
        slot_wdata = {LKW'(idx_reg) + LKW'(1), {CW{1'b0}}};
        if (state_reg == S_CLEAR)
        begin
            // free list relinked in slot order
            slot_we = 1'b1;
        end
        else if (match_hit)
        begin
            slot_we    = 1'b1;
            slot_wdata = {link_reg, hit_sum};
        end
        else if (evict_now)
        begin
            // evicted slot goes on top of the free list
            slot_we    = 1'b1;
            slot_wdata = {head_reg, {CW{1'b0}}};
        end
        else if (state_reg == S_ALLOCW)
        begin
            slot_we    = 1'b1;
            slot_waddr = slot_reg;
            slot_wdata = {slot_link, CW'(w_reg)};
        end
    end

    // key memory port steering
    always_comb
    begin
        case (state_reg)
            S_IDLE:  key_raddr = {SW'(sample.read_slot), DW'(sample.read_word)};
            S_MCHK:  key_raddr = {idx_reg, DW'(0)};
            default: key_raddr = {idx_reg, j_reg + DW'(1)};
        endcase
        key_we    = (state_reg == S_KWR);
        key_waddr = {slot_reg, j_reg};
    end

    stct_ram #(
        .WIDTH (SMW),
        .DEPTH (ENTRIES)
    ) u_slot_ram (
        .clk   (clk),
        .we    (slot_we),
        .waddr (slot_waddr),
        .wdata (slot_wdata),
        .raddr (slot_raddr),
        .rdata (slot_rdata)
    );

    stct_ram #(
        .WIDTH (64),
        .DEPTH (ENTRIES << DW)
    ) u_key_ram (
        .clk   (clk),
        .we    (key_we),
        .waddr (key_waddr),
        .wdata (expect_word),
        .raddr (key_raddr),
        .rdata (key_rdata)
    );

    stct_median #(
        .ENTRIES (ENTRIES)
    ) u_median (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (med_start),
        .count   (slot_cnt),
        .raddr   (med_raddr),
        .outcome (med_st)
    );

    // sequencer control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            idx_reg       <= '0;
            j_reg         <= '0;
            pos_reg       <= '0;
            kept_reg      <= '0;
            depth_reg     <= stct_pkg::TD_RESET;
            gc_reg        <= '0;
            disc_reg      <= '0;
            head_reg      <= '0;
            clr_pend_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                depth_reg <= cfg_data;
            end
            // a new word may replace the one taken at the same edge
            if (res_load)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (result_valid && result_ready)
            begin
                res_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_CLEAR:
                begin
                    if (last_slot)
                    begin
                        idx_reg      <= '0;
                        clr_pend_reg <= 1'b0;
                        state_reg    <= clr_pend_reg ? S_DONE : S_IDLE;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + SW'(1);
                    end
                end
                S_IDLE:
                begin
                    if (acc)
                    begin
                        case (sample.opcode)
                            stct_pkg::OP_FRAME:
                            begin
                                if (int'(pos_reg) < MAX_DEPTH)
                                begin
                                    pos_reg <= pos_reg + PW'(1);
                                end
                                if (frame_keep)
                                begin
                                    kept_reg[DW'(pos_reg)] <= 1'b1;
                                end
                                if (sample.last_frame)
                                begin
                                    idx_reg   <= '0;
                                    state_reg <= S_MCNT;
                                end
                            end
                            stct_pkg::OP_GC:
                            begin
                                gc_reg    <= sat_add(gc_reg, CW'(sample.weight));
                                state_reg <= S_DONE;
                            end
                            stct_pkg::OP_READ:
                            begin
                                state_reg <= S_READ;
                            end
                            stct_pkg::OP_CLEAR:
                            begin
                                pos_reg      <= '0;
                                kept_reg     <= '0;
                                gc_reg       <= '0;
                                disc_reg     <= '0;
                                head_reg     <= '0;
                                idx_reg      <= '0;
                                clr_pend_reg <= 1'b1;
                                state_reg    <= S_CLEAR;
                            end
                            default:
                            begin
                                state_reg <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_READ:
                begin
                    state_reg <= S_DONE;
                end
                S_MCNT:
                begin
                    state_reg <= S_MCHK;
                end
                S_MCHK, S_MKEY:
                begin
                    if (match_miss)
                    begin
                        idx_reg   <= '0;
                        state_reg <= head_empty ? S_MED : S_ALLOC;
                    end
                    else if (match_next)
                    begin
                        idx_reg   <= idx_reg + SW'(1);
                        state_reg <= S_MCNT;
                    end
                    else if (match_hit)
                    begin
                        pos_reg   <= '0;
                        kept_reg  <= '0;
                        state_reg <= S_DONE;
                    end
                    else if (state_reg == S_MCHK)
                    begin
                        j_reg     <= '0;
                        state_reg <= S_MKEY;
                    end
                    else
                    begin
                        j_reg <= j_reg + DW'(1);
                    end
                end
                S_MED:
                begin
                    if (med_st.done)
                    begin
                        idx_reg   <= '0;
                        state_reg <= S_EVRD;
                    end
                end
                S_EVRD:
                begin
                    state_reg <= S_EVCHK;
                end
                S_EVCHK:
                begin
                    if (evict_now)
                    begin
                        disc_reg <= sat_add(disc_reg, slot_cnt);
                        head_reg <= LKW'(idx_reg);
                    end
                    if (last_slot)
                    begin
                        state_reg <= S_ALLOC;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + SW'(1);
                        state_reg <= S_EVRD;
                    end
                end
                S_ALLOC:
                begin
                    state_reg <= S_ALLOCW;
                end
                S_ALLOCW:
                begin
                    head_reg  <= slot_link;
                    j_reg     <= '0;
                    state_reg <= S_KWR;
                end
                S_KWR:
                begin
                    if (j_end)
                    begin
                        pos_reg   <= '0;
                        kept_reg  <= '0;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        j_reg <= j_reg + DW'(1);
                    end
                end
                S_DONE:
                begin
                    if (res_load)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // payload: trace buffer, working values and the output word
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (acc)
                begin
                    nev_reg    <= '0;
                    oword_reg  <= '0;
                    ocnt_reg   <= '0;
                    oslot_reg  <= '0;
                    status_reg <= stct_pkg::ST_DONE;
                    if (sample.opcode == stct_pkg::OP_FRAME)
                    begin
                        if (frame_keep)
                        begin
                            buf_reg[DW'(pos_reg)] <= sample.frame_address;
                        end
                        w_reg <= weight_nz;
                    end
                    else if (sample.opcode == stct_pkg::OP_READ)
                    begin
                        status_reg <= stct_pkg::ST_READOUT;
                        oslot_reg  <= sample.read_slot;
                        rd_ok_reg  <= int'(sample.read_slot) < ENTRIES;
                        wd_ok_reg  <= int'(sample.read_word) < MAX_DEPTH;
                    end
                end
            end
            S_READ:
            begin
                ocnt_reg  <= rd_ok_reg ? slot_cnt : '0;
                oword_reg <= (rd_ok_reg && wd_ok_reg) ? key_rdata : 64'd0;
            end
            S_MCHK, S_MKEY:
            begin
                if (state_reg == S_MCHK)
                begin
                    cnt_reg  <= slot_cnt;
                    link_reg <= slot_link;
                end
                if (match_hit)
                begin
                    status_reg <= stct_pkg::ST_HIT;
                    oslot_reg  <= 6'(idx_reg);
                    ocnt_reg   <= hit_sum;
                end
                if (match_miss)
                begin
                    status_reg <= head_empty ? stct_pkg::ST_NEW_EVICT : stct_pkg::ST_NEW;
                end
            end
            S_MED:
            begin
                if (med_st.done)
                begin
                    med_reg <= med_st.median;
                end
            end
            S_EVCHK:
            begin
                if (evict_now)
                begin
                    nev_reg <= nev_reg + LKW'(1);
                end
            end
            S_ALLOC:
            begin
                slot_reg <= alloc_slot;
            end
            S_ALLOCW:
            begin
                ocnt_reg  <= CW'(w_reg);
                oslot_reg <= 6'(slot_reg);
            end
            S_DONE:
            begin
                if (res_load)
                begin
                    res_reg.status          <= status_reg;
                    res_reg.entry_slot      <= oslot_reg;
                    res_reg.entry_count     <= ocnt_reg;
                    res_reg.key_word        <= oword_reg;
                    res_reg.evicted_entries <= 7'(nev_reg);
                    res_reg.gc_total        <= gc_reg;
                    res_reg.discarded_total <= disc_reg;
                end
            end
            default:
            begin
                w_reg <= w_reg;
            end
        endcase
    end

    // a sweep over a full table always frees at least one slot
    a_evict_frees: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EVCHK && last_slot) |=> (nev_reg != '0))
        else $error("eviction sweep freed no slot");

    // memories are quiet while waiting for an item
    a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (!slot_we && !key_we))
        else $error("memory write while idle");

    // the median unit only reports while the sequencer waits on it
    a_med_owner: assert property (@(posedge clk) disable iff (!rst_n)
        med_st.done |-> (state_reg == S_MED))
        else $error("median result outside the median wait");

    // an output word only appears out of the finishing state
    a_load_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> ($past(state_reg) == S_DONE))
        else $error("output word loaded outside the finishing state");

endmodule

// File: verif/tb.sv
// testbench for the sample trace count table: random and directed samples checked against a predictor
`timescale 1ns / 100ps

module tb;

    localparam int NSLOT  = 64;
    localparam int NDEPTH = 16;
    localparam int WATCH_LIMIT = 400000;
    localparam int CW = stct_pkg::CNT_W;

    // ------------------------------------------------------------------
    // scoreboard: a private copy of the table, predicts one result word
    // per completed trace, gc, read or clear
    // ------------------------------------------------------------------
    class count_table_board;
        logic [63:0]       keys [NSLOT*NDEPTH];
        logic [CW-1:0]     counts [NSLOT];
        int                links [NSLOT];
        int                head;
        logic [63:0]       trace [NDEPTH];
        int                fpos;
        logic [CW-1:0]     gc_sum;
        logic [CW-1:0]     lost_sum;
        logic [4:0]        depth_reg;
        bit                written [NSLOT];
        stct_pkg::result_t pending [$];
        int                errors;

        function new();
            depth_reg = stct_pkg::TD_RESET;
            errors = 0;
            foreach (written[i]) written[i] = 0;
            foreach (keys[i]) keys[i] = '0;
            wipe();
        endfunction

        function void wipe();
            for (int i = 0; i < NSLOT; i++)
            begin
                counts[i] = '0;
                links[i] = i + 1;
            end
            head = 0;
            foreach (trace[i]) trace[i] = '0;
            fpos = 0;
            gc_sum = '0;
            lost_sum = '0;
        endfunction

        function logic [CW-1:0] sat_sum(logic [CW-1:0] a, logic [63:0] b);
            logic [63:0] s;
            s = {3'b0, a} + b;
            return (s > {3'b0, stct_pkg::CNT_MAX}) ? stct_pkg::CNT_MAX : s[CW-1:0];
        endfunction

        function int used_depth();
            if (depth_reg == 0) return 1;
            if (depth_reg > NDEPTH) return NDEPTH;
            return int'(depth_reg);
        endfunction

        function logic [CW-1:0] range_median(int start, int size);
            int third;
            logic [CW-1:0] a, b, c;
            logic [CW:0] s2;
            if (size < 2) return counts[start];
            if (size < 3)
            begin
                s2 = {1'b0, counts[start]} + {1'b0, counts[start+1]};
                return s2[CW:1];
            end
            third = size / 3;
            a = range_median(start, third);
            b = range_median(start + third, third);
            c = range_median(start + 2*third, size - 2*third);
            if (a < b) return (b < c) ? b : ((a > c) ? a : c);
            return (a < c) ? a : ((b > c) ? b : c);
        endfunction

        function int evict_low();
            logic [CW-1:0] med;
            int n;
            med = range_median(0, NSLOT);
            n = 0;
            for (int i = 0; i < NSLOT; i++)
                if (counts[i] <= med)
                begin
                    lost_sum = sat_sum(lost_sum, {3'b0, counts[i]});
                    counts[i] = '0;
                    links[i] = head;
                    head = i;
                    n++;
                end
            return n;
        endfunction

        // note an accepted sample and queue its expected word, if any
        function void note_sample(stct_pkg::sample_t s);
            stct_pkg::result_t r;
            int hit, slot;
            bit same;
            logic [63:0] w;
            r = '0;
            r.status = stct_pkg::ST_DONE;
            case (s.opcode)
                stct_pkg::OP_FRAME:
                begin
                    if (fpos < used_depth()) trace[fpos] = s.frame_address;
                    if (fpos < NDEPTH) fpos++;
                    if (!s.last_frame) return;
                    for (int j = fpos; j < NDEPTH; j++) trace[j] = '0;
                    w = {32'b0, s.weight};
                    if (w == 0) w = 1;
                    hit = -1;
                    for (int i = 0; i < NSLOT && hit < 0; i++)
                        if (counts[i] != 0)
                        begin
                            same = 1;
                            for (int j = 0; j < NDEPTH; j++)
                                if (keys[i*NDEPTH+j] != trace[j]) same = 0;
                            if (same) hit = i;
                        end
                    if (hit >= 0)
                    begin
                        counts[hit] = sat_sum(counts[hit], w);
                        r.status = stct_pkg::ST_HIT;
                        r.entry_slot = 6'(hit);
                        r.entry_count = counts[hit];
                    end
                    else
                    begin
                        r.status = stct_pkg::ST_NEW;
                        if (head >= NSLOT)
                        begin
                            r.evicted_entries = 7'(evict_low());
                            r.status = stct_pkg::ST_NEW_EVICT;
                        end
                        slot = (head >= NSLOT) ? 0 : head;
                        head = links[slot];
                        for (int j = 0; j < NDEPTH; j++) keys[slot*NDEPTH+j] = trace[j];
                        written[slot] = 1;
                        counts[slot] = w[CW-1:0];
                        r.entry_slot = 6'(slot);
                        r.entry_count = counts[slot];
                    end
                    foreach (trace[i]) trace[i] = '0;
                    fpos = 0;
                end
                stct_pkg::OP_GC: gc_sum = sat_sum(gc_sum, {32'b0, s.weight});
                stct_pkg::OP_READ:
                begin
                    r.status = stct_pkg::ST_READOUT;
                    r.entry_slot = s.read_slot;
                    r.entry_count = counts[s.read_slot];
                    r.key_word = keys[s.read_slot*NDEPTH + s.read_word];
                end
                default: wipe();
            endcase
            r.gc_total = gc_sum;
            r.discarded_total = lost_sum;
            pending.push_back(r);
        endfunction

        // compare one accepted result word with the oldest expectation
        function void check_result(stct_pkg::result_t got);
            stct_pkg::result_t e;
            if (pending.size() == 0)
            begin
                $error("unexpected result word %h", got);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.status !== e.status)
            begin
                $error("status exp %0d got %0d", e.status, got.status); errors++;
            end
            if (got.entry_slot !== e.entry_slot)
            begin
                $error("entry_slot exp %0d got %0d", e.entry_slot, got.entry_slot); errors++;
            end
            if (got.entry_count !== e.entry_count)
            begin
                $error("entry_count exp %0d got %0d", e.entry_count, got.entry_count);
                errors++;
            end
            if (got.key_word !== e.key_word)
            begin
                $error("key_word exp %h got %h", e.key_word, got.key_word); errors++;
            end
            if (got.evicted_entries !== e.evicted_entries)
            begin
                $error("evicted_entries exp %0d got %0d", e.evicted_entries,
                       got.evicted_entries);
                errors++;
            end
            if (got.gc_total !== e.gc_total)
            begin
                $error("gc_total exp %0d got %0d", e.gc_total, got.gc_total); errors++;
            end
            if (got.discarded_total !== e.discarded_total)
            begin
                $error("discarded_total exp %0d got %0d", e.discarded_total,
                       got.discarded_total);
                errors++;
            end
        endfunction
    endclass

    logic              clk = 0;
    logic              rst_n = 0;
    logic              sample_valid = 0;
    logic              sample_ready;
    stct_pkg::sample_t sample = '0;
    logic              result_valid;
    logic              result_ready = 0;
    stct_pkg::result_t result;
    logic              cfg_valid = 0;
    logic              cfg_ready;
    logic [stct_pkg::TD_W-1:0] cfg_data = '0;

    count_table_board board = new();
    int  quiet_cycles = 0;
    bit  sink_on = 0;
    logic [63:0] addr_pool [8];

    always #1 clk = ~clk;

    sample_trace_count_table dut (
        .clk(clk), .rst_n(rst_n),
        .sample_valid(sample_valid), .sample_ready(sample_ready), .sample(sample),
        .result_valid(result_valid), .result_ready(result_ready), .result(result),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    // mostly short gaps, now and then a long one
    function int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 80);
    endfunction

    // watchdog: cycles with no word moving on any channel
    always @(posedge clk)
    begin
        if ((sample_valid && sample_ready) || (result_valid && result_ready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCH_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // result side: check accepted words, stall at random
    always @(posedge clk)
    begin
        if (result_valid && result_ready)
            board.check_result(result);
    end

    initial
    begin
        int g;
        wait (sink_on);
        forever
        begin
            g = gap_len();
            if (g > 0)
            begin
                result_ready <= 0;
                repeat (g) @(posedge clk);
            end
            result_ready <= 1;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    end

    // send one sample word and hand it to the scoreboard when taken;
    // valid stays up so that a following word can go out back to back
    task automatic send_sample(stct_pkg::sample_t s);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            sample_valid <= 0;
            repeat (g) @(posedge clk);
        end
        sample_valid <= 1;
        sample <= s;
        @(posedge clk);
        while (!sample_ready) @(posedge clk);
        board.note_sample(s);
    endtask

    // drop valid once the last word of a burst has been taken
    task automatic stop_samples();
        sample_valid <= 0;
    endtask

    task automatic write_depth(logic [stct_pkg::TD_W-1:0] d);
        stop_samples();
        // block idle: all results in, then room for a trailing partial frame
        while (board.pending.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        cfg_valid <= 1;
        cfg_data <= d;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        board.depth_reg = d;
        cfg_valid <= 0;
    endtask

    function stct_pkg::sample_t rand_fields();
        stct_pkg::sample_t s;
        s.opcode = 2'($urandom_range(0, 3));
        s.frame_address = {$urandom, $urandom};
        s.last_frame = 1'($urandom_range(0, 1));
        s.weight = $urandom;
        s.read_slot = 6'($urandom_range(0, NSLOT-1));
        s.read_word = 4'($urandom_range(0, NDEPTH-1));
        return s;
    endfunction

    // one whole trace; addresses from a small pool so traces repeat
    task automatic send_trace(int len, logic [31:0] w);
        stct_pkg::sample_t s;
        for (int i = 0; i < len; i++)
        begin
            s = rand_fields();
            s.opcode = stct_pkg::OP_FRAME;
            s.frame_address = addr_pool[$urandom_range(0, 7)];
            s.last_frame = (i == len - 1);
            if (i == len - 1) s.weight = w;
            send_sample(s);
        end
    endtask

    // a read only of slots that have been allocated since reset, else a zero-weight gc
    task automatic send_read();
        stct_pkg::sample_t s;
        int k;
        s = rand_fields();
        s.opcode = stct_pkg::OP_READ;
        k = 0;
        while (!board.written[s.read_slot] && k < 200)
        begin
            s.read_slot = 6'($urandom_range(0, NSLOT-1));
            k++;
        end
        if (!board.written[s.read_slot])
        begin
            s.opcode = stct_pkg::OP_GC;
            s.weight = 0;
        end
        send_sample(s);
    endtask

    task automatic random_weight(output logic [31:0] w);
        case ($urandom_range(0, 5))
            0: w = 0;
            1: w = 32'hFFFF_FFFF;
            2: w = $urandom_range(1, 4);
            default: w = $urandom;
        endcase
    endtask

    initial
    begin
        stct_pkg::sample_t s;
        logic [31:0] w;
        for (int i = 0; i < 8; i++) addr_pool[i] = {$urandom, $urandom};
        addr_pool[0] = '0;
        addr_pool[1] = '1;
        repeat (9) @(posedge clk);
        rst_n <= 1;
        sink_on = 1;

        // directed: extremes, each opcode, depth limits, zero weight, long trace
        send_trace(1, 0);
        send_trace(1, 32'hFFFF_FFFF);
        send_trace(3, 5);
        send_read();
        s = rand_fields(); s.opcode = stct_pkg::OP_GC; s.weight = 32'hFFFF_FFFF;
        send_sample(s);
        s = rand_fields(); s.opcode = stct_pkg::OP_GC; s.weight = 0; send_sample(s);
        send_trace(20, 7);
        s = rand_fields(); s.opcode = stct_pkg::OP_FRAME; s.last_frame = 0; send_sample(s);
        s = rand_fields(); s.opcode = stct_pkg::OP_CLEAR; send_sample(s);
        write_depth(5'd0);
        send_trace(2, 3);
        send_trace(1, 3);
        write_depth(5'd31);
        send_trace(18, 1);
        write_depth(5'd1);
        send_trace(4, 2);

        // random phases at several depths; traces dominate so the table fills
        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: write_depth(5'd16);
                1: write_depth(5'd2);
                2: write_depth(5'd17);
                3: write_depth(5'd1);
                4: write_depth(5'd0);
                default: write_depth(5'($urandom_range(3, 15)));
            endcase
            for (int i = 0; i < 70; i++)
            begin
                case ($urandom_range(0, 19))
                    0:
                    begin
                        s = rand_fields(); s.opcode = stct_pkg::OP_GC; send_sample(s);
                    end
                    1, 2: send_read();
                    3:
                    begin
                        if ($urandom_range(0, 3) == 0)
                        begin
                            s = rand_fields(); s.opcode = stct_pkg::OP_CLEAR; send_sample(s);
                        end
                        else
                            send_read();
                    end
                    4:
                    begin
                        s = rand_fields();
                        if (s.opcode == stct_pkg::OP_READ) s.opcode = stct_pkg::OP_GC;
                        send_sample(s);
                    end
                    default:
                    begin
                        random_weight(w);
                        if ($urandom_range(0, 9) == 0)
                            send_trace($urandom_range(1, 20), w);
                        else
                            send_trace($urandom_range(1, 3), w);
                    end
                endcase
            end
        end
        // finish any partial trace so every word has an answer
        send_trace(1, 1);
        stop_samples();

        while (board.pending.size() != 0) @(posedge clk);
        repeat (400) @(posedge clk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
